// ===== rtl/xmt_pkg.sv =====
// ----------------------------------------------------------------------------
// xmt_pkg: shared types and constants of the markup tokenizer
// Scan modes, token kinds, error codes and character class functions.
// ----------------------------------------------------------------------------
package xmt_pkg;

	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_LT      = 4'd1,
		M_BANG    = 4'd2,
		M_CDATA   = 4'd3,
		M_COMMENT = 4'd4,
		M_PI      = 4'd5,
		M_SLASH   = 4'd6,
		M_WS      = 4'd7,
		M_NAME    = 4'd8,
		M_TEXT    = 4'd9,
		M_STRING  = 4'd10
	} mode_t;

	localparam logic [3:0] K_CDATA   = 4'd0;
	localparam logic [3:0] K_COMMENT = 4'd1;
	localparam logic [3:0] K_PI      = 4'd2;
	localparam logic [3:0] K_ETAG    = 4'd3;
	localparam logic [3:0] K_LT      = 4'd4;
	localparam logic [3:0] K_EMPTY   = 4'd5;
	localparam logic [3:0] K_GT      = 4'd6;
	localparam logic [3:0] K_LBRACE  = 4'd7;
	localparam logic [3:0] K_RBRACE  = 4'd8;
	localparam logic [3:0] K_EQ      = 4'd9;
	localparam logic [3:0] K_SPACE   = 4'd10;
	localparam logic [3:0] K_STRING  = 4'd11;
	localparam logic [3:0] K_NAME    = 4'd12;
	localparam logic [3:0] K_TEXT    = 4'd13;
	localparam logic [3:0] K_END     = 4'd14;

	localparam logic [2:0] E_NONE    = 3'd0;
	localparam logic [2:0] E_END     = 3'd1;
	localparam logic [2:0] E_BANG    = 3'd2;
	localparam logic [2:0] E_SLASH   = 3'd3;
	localparam logic [2:0] E_DASH    = 3'd4;
	localparam logic [2:0] E_UNTERM  = 3'd5;

	localparam logic [3:0] BANG_DASH = 4'd8;

	function automatic logic is_letter(input logic [15:0] c);
		logic [15:0] l;
		l = c | 16'h0020;
		return (l >= 16'h0061 && l <= 16'h007A) ||
			(c >= 16'h00C0 && c != 16'h00D7 && c != 16'h00F7);
	endfunction

	function automatic logic name_start(input logic [15:0] c);
		return is_letter(c) || c == 16'h003A || c == 16'h005F;
	endfunction

	function automatic logic name_next(input logic [15:0] c);
		return name_start(c) || (c >= 16'h0030 && c <= 16'h0039) ||
			c == 16'h002E || c == 16'h002D;
	endfunction

	function automatic logic is_space(input logic [15:0] c);
		return c == 16'h0020 || c == 16'h0009 || c == 16'h000D || c == 16'h000A;
	endfunction

	function automatic logic text_stop(input logic [15:0] c);
		return is_space(c) || c == 16'h007B || c == 16'h007D || c == 16'h003C ||
			c == 16'h003E || c == 16'h002F || c == 16'h003D || name_start(c);
	endfunction

	// "[CDATA[" by match position
	function automatic logic [15:0] cdata_char(input logic [3:0] p);
		logic [15:0] r;
		case (p)
			4'd0: r = 16'h005B;
			4'd1: r = 16'h0043;
			4'd2: r = 16'h0044;
			4'd3: r = 16'h0041;
			4'd4: r = 16'h0054;
			4'd5: r = 16'h0041;
			4'd6: r = 16'h005B;
			default: r = 16'hFFFF;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/xml_markup_tokenizer.sv =====
// ----------------------------------------------------------------------------
// xml_markup_tokenizer: streaming markup tokenizer
// One 16-bit code unit per beat in; token records out.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata fields (low bit up)                  tuser  tlast
// s_axis   in   code_unit[15:0]                            cmd    -
// m_axis   out  kind[3:0] len[LB-1:0] line[LN-1:0] err[2:0] -     last
//
// One code unit per cycle while the output is ready and the queue has room. The
// scan state updates in the cycle a beat is taken; a beat yields up to two
// records, which go to a two-entry registered output queue. Input is taken
// whenever the queue has room for two records, so a beat that yields two
// records stalls the input until a record leaves the queue. Reset clears the
// scan state and the queue. Output stalls hold the queue.
// ----------------------------------------------------------------------------
module xml_markup_tokenizer #(
	parameter int LENGTH_BITS = 16,
	parameter int LINE_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // code_unit
	input  logic s_axis_tuser,         // cmd
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// token_kind, token_length, token_line, error_code, zero pad
	output logic [((4+LENGTH_BITS+LINE_BITS+3+7)/8)*8-1:0] m_axis_tdata,
	output logic m_axis_tlast           // last
);
	import xmt_pkg::*;

	localparam int RW = 4 + LENGTH_BITS + LINE_BITS + 3;
	localparam int DW = ((RW + 7) / 8) * 8;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
	localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

	typedef struct packed {
		logic [3:0] kind;
		logic [LENGTH_BITS-1:0] len;
		logic [LINE_BITS-1:0] line;
		logic [2:0] err;
		logic last;
	} rec_t;

	mode_t mode_q, mode_d;
	logic [3:0] prog_q, prog_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [LINE_BITS-1:0] sline_q, sline_d, line_q, line_d;
	logic [15:0] quote_q, quote_d;
	logic cr_q, cr_d;

	rec_t rec0, rec1;
	logic v0, v1;

	rec_t fifo_q [2];
	logic [1:0] cnt_q;
	logic acc, pop;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign pop = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready);

	// next scan state and records for one code unit
	always_comb begin
		logic [15:0] c;
		logic [LENGTH_BITS-1:0] lg;
		logic restart;
		logic [LENGTH_BITS-1:0] one;
		c = s_axis_tdata;
		one = LENGTH_BITS'(1);
		lg = (len_q == LEN_MAX) ? len_q : len_q + one;
		mode_d = mode_q; prog_d = prog_q; len_d = len_q; sline_d = sline_q;
		line_d = line_q; quote_d = quote_q; cr_d = cr_q;
		rec0 = '0; rec1 = '0; v0 = 1'b0; v1 = 1'b0; restart = 1'b0;
		if (s_axis_tuser) begin
			v0 = 1'b1;
			rec0.last = 1'b1;
			rec0.len = len_q;
			case (mode_q)
				M_LT, M_WS, M_NAME, M_TEXT: begin
					rec0.kind = (mode_q == M_LT) ? K_LT : (mode_q == M_WS) ? K_SPACE :
						(mode_q == M_NAME) ? K_NAME : K_TEXT;
					rec0.line = sline_q; rec0.last = 1'b0;
					v1 = 1'b1; rec1.kind = K_END; rec1.line = line_q;
					rec1.err = E_END; rec1.last = 1'b1;
				end
				M_BANG: begin rec0.kind = K_LT; rec0.line = line_q; rec0.err = E_BANG; end
				M_SLASH: begin rec0.kind = K_EMPTY; rec0.line = line_q; rec0.err = E_SLASH; end
				M_CDATA, M_PI, M_STRING: begin
					rec0.kind = (mode_q == M_CDATA) ? K_CDATA : (mode_q == M_PI) ? K_PI : K_STRING;
					rec0.line = sline_q; rec0.err = E_UNTERM;
				end
				M_COMMENT: begin
					rec0.kind = K_COMMENT;
					if (prog_q >= 4'd2) begin rec0.line = line_q; rec0.err = E_DASH; end
					else begin rec0.line = sline_q; rec0.err = E_UNTERM; end
				end
				default: begin rec0.kind = K_END; rec0.len = '0; rec0.line = line_q; rec0.err = E_END; end
			endcase
			mode_d = M_IDLE; prog_d = '0; len_d = '0; sline_d = LINE_ONE;
			line_d = LINE_ONE; quote_d = '0; cr_d = 1'b0;
		end else begin
			case (mode_q)
				M_LT: begin
					if (c == 16'h0021) begin len_d = lg; mode_d = M_BANG; prog_d = '0; end
					else if (c == 16'h003F) begin len_d = lg; mode_d = M_PI; prog_d = '0; end
					else if (c == 16'h002F) begin
						v0 = 1'b1; rec0.kind = K_ETAG; rec0.len = lg; rec0.line = sline_q;
						len_d = lg; mode_d = M_IDLE; prog_d = '0;
					end else begin
						v0 = 1'b1; rec0.kind = K_LT; rec0.len = len_q; rec0.line = sline_q;
						restart = 1'b1;
					end
				end
				M_BANG: begin
					if (prog_q == 4'd0 && c == 16'h005B) begin len_d = lg; prog_d = 4'd1; end
					else if (prog_q == 4'd0 && c == 16'h002D) begin len_d = lg; prog_d = BANG_DASH; end
					else if (prog_q == BANG_DASH && c == 16'h002D) begin
						len_d = lg; mode_d = M_COMMENT; prog_d = '0;
					end else if (prog_q >= 4'd1 && prog_q <= 4'd6 && c == cdata_char(prog_q)) begin
						len_d = lg;
						if (prog_q == 4'd6) begin mode_d = M_CDATA; prog_d = '0; end
						else prog_d = prog_q + 4'd1;
					end else begin
						v0 = 1'b1; rec0.kind = K_LT; rec0.len = len_q; rec0.line = line_q;
						rec0.err = E_BANG; mode_d = M_IDLE; prog_d = '0;
					end
				end
				M_CDATA: begin
					if (prog_q >= 4'd2 && c == 16'h003E) begin
						v0 = 1'b1; rec0.kind = K_CDATA; rec0.len = lg; rec0.line = sline_q;
						len_d = lg; mode_d = M_IDLE; prog_d = '0;
					end else begin
						len_d = lg;
						prog_d = (c == 16'h005D) ? ((prog_q >= 4'd2) ? 4'd2 : prog_q + 4'd1) : 4'd0;
					end
				end
				M_COMMENT: begin
					if (prog_q >= 4'd2) begin
						v0 = 1'b1; mode_d = M_IDLE; prog_d = '0;
						if (c == 16'h003E) begin
							rec0.kind = K_COMMENT; rec0.len = lg; rec0.line = sline_q; len_d = lg;
						end else begin
							rec0.kind = K_COMMENT; rec0.len = len_q; rec0.line = line_q; rec0.err = E_DASH;
						end
					end else begin
						len_d = lg; prog_d = (c == 16'h002D) ? prog_q + 4'd1 : 4'd0;
					end
				end
				M_PI: begin
					if (prog_q == 4'd1 && c == 16'h003E) begin
						v0 = 1'b1; rec0.kind = K_PI; rec0.len = lg; rec0.line = sline_q;
						len_d = lg; mode_d = M_IDLE; prog_d = '0;
					end else begin
						len_d = lg; prog_d = (c == 16'h003F) ? 4'd1 : 4'd0;
					end
				end
				M_SLASH: begin
					v0 = 1'b1; mode_d = M_IDLE; prog_d = '0;
					if (c == 16'h003E) begin
						rec0.kind = K_EMPTY; rec0.len = lg; rec0.line = sline_q; len_d = lg;
					end else begin
						rec0.kind = K_EMPTY; rec0.len = len_q; rec0.line = line_q; rec0.err = E_SLASH;
					end
				end
				M_WS: begin
					if (is_space(c)) len_d = lg;
					else begin
						v0 = 1'b1; rec0.kind = K_SPACE; rec0.len = len_q; rec0.line = sline_q;
						restart = 1'b1;
					end
				end
				M_NAME: begin
					if (name_next(c)) len_d = lg;
					else begin
						v0 = 1'b1; rec0.kind = K_NAME; rec0.len = len_q; rec0.line = sline_q;
						restart = 1'b1;
					end
				end
				M_TEXT: begin
					if (!text_stop(c)) len_d = lg;
					else begin
						v0 = 1'b1; rec0.kind = K_TEXT; rec0.len = len_q; rec0.line = sline_q;
						restart = 1'b1;
					end
				end
				M_STRING: begin
					if (c == quote_q) begin
						v0 = 1'b1; rec0.kind = K_STRING; rec0.len = lg; rec0.line = sline_q;
						len_d = lg; mode_d = M_IDLE; prog_d = '0;
					end else len_d = lg;
				end
				default: restart = 1'b1;
			endcase
			// idle handling of the unit, also after a closed token
			if (restart) begin
				rec_t r;
				logic rv;
				r = '0; rv = 1'b0;
				r.len = one; r.line = line_q;
				mode_d = M_IDLE; prog_d = '0;
				case (c)
					16'h003E: begin rv = 1'b1; r.kind = K_GT; end
					16'h007B: begin rv = 1'b1; r.kind = K_LBRACE; end
					16'h007D: begin rv = 1'b1; r.kind = K_RBRACE; end
					16'h003D: begin rv = 1'b1; r.kind = K_EQ; end
					default: begin
						len_d = one; sline_d = line_q;
						if (c == 16'h003C) mode_d = M_LT;
						else if (c == 16'h002F) mode_d = M_SLASH;
						else if (c == 16'h0022 || c == 16'h0027) begin
							mode_d = M_STRING; quote_d = c;
						end else if (is_space(c)) mode_d = M_WS;
						else if (name_start(c)) mode_d = M_NAME;
						else mode_d = M_TEXT;
					end
				endcase
				if (rv) begin
					if (v0) begin v1 = 1'b1; rec1 = r; end
					else begin v0 = 1'b1; rec0 = r; end
				end
			end
			// line counting
			if (c == 16'h000D) begin line_d = line_q + LINE_ONE; cr_d = 1'b1; end
			else begin
				if (c == 16'h000A && !cr_q) line_d = line_q + LINE_ONE;
				cr_d = 1'b0;
			end
		end
	end

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; prog_q <= '0; len_q <= '0;
			sline_q <= LINE_ONE; line_q <= LINE_ONE; quote_q <= '0; cr_q <= 1'b0;
		end else if (acc) begin
			mode_q <= mode_d; prog_q <= prog_d; len_q <= len_d;
			sline_q <= sline_d; line_q <= line_d; quote_q <= quote_d; cr_q <= cr_d;
		end
	end

	// two-entry output queue, head in entry 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			logic [1:0] base;
			base = cnt_q - {1'b0, pop};
			cnt_q <= base + {1'b0, acc && v0} + {1'b0, acc && v1};
		end
	end

	always_ff @(posedge clk) begin
		logic [1:0] base;
		base = cnt_q - {1'b0, pop};
		if (acc && v0 && base == 2'd0) begin
			fifo_q[0] <= rec0;
			if (v1) fifo_q[1] <= rec1;
		end else begin
			if (pop) fifo_q[0] <= fifo_q[1];
			if (acc && v0) fifo_q[1] <= rec0;
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata = DW'({fifo_q[0].err, fifo_q[0].line, fifo_q[0].len, fifo_q[0].kind});
	assign m_axis_tlast = fifo_q[0].last;

endmodule

// ===== rtl/xmt_checker.sv =====
// ----------------------------------------------------------------------------
// xmt_checker: port-level checks of the markup tokenizer
// Watches handshakes and record contents on the top-level ports.
// ----------------------------------------------------------------------------
module xmt_checker #(
	parameter int DW = 56
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [DW-1:0] m_axis_tdata,
	input logic m_axis_tlast
);
	// a stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed under stall");

	// kind code stays in range
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd14)
		else $error("bad token kind");

	// with nothing queued the input side is open
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// end-kind records carry zero length and the last flag
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3:0] == 4'd14 |-> m_axis_tdata[19:4] == 16'd0
		&& m_axis_tlast)
		else $error("bad end record");
endmodule

bind xml_markup_tokenizer xmt_checker #(.DW(((4+LENGTH_BITS+LINE_BITS+3+7)/8)*8)) u_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast));

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the markup tokenizer
// Drives code units and end markers into the tokenizer and checks every
// token record against a cycle-free scanner written here, in order.
// ----------------------------------------------------------------------------
module tb;
	import xmt_pkg::*;

	localparam int LB = 16;
	localparam int LN = 24;
	localparam int TDW = ((4+LB+LN+3+7)/8)*8;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [3:0] kind;
		logic [15:0] len;
		logic [23:0] line;
		logic [2:0] err;
		logic last;
	} token_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [TDW-1:0] m_axis_tdata;
	logic m_axis_tlast;

	xml_markup_tokenizer dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// scanner copy
	mode_t sc_mode;
	logic [3:0] sc_prog;
	logic [15:0] sc_len;
	logic [23:0] sc_start;
	logic [23:0] sc_line;
	logic [15:0] sc_quote;
	logic sc_cr;

	token_t expected_tokens[$];
	int mismatches = 0;
	int tokens_seen = 0;
	int units_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] cdata_at(input logic [3:0] p);
		case (p)
			4'd0, 4'd6: return 16'h005B;
			4'd1: return 16'h0043;
			4'd2: return 16'h0044;
			4'd3, 4'd5: return 16'h0041;
			4'd4: return 16'h0054;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic logic letter_u(input logic [15:0] c);
		logic [15:0] l;
		l = c | 16'h0020;
		return (l >= "a" && l <= "z") || (c >= 16'h00C0 && c != 16'h00D7 && c != 16'h00F7);
	endfunction

	function automatic logic nstart_u(input logic [15:0] c);
		return letter_u(c) || c == ":" || c == "_";
	endfunction

	function automatic logic nnext_u(input logic [15:0] c);
		return nstart_u(c) || (c >= "0" && c <= "9") || c == "." || c == "-";
	endfunction

	function automatic logic space_u(input logic [15:0] c);
		return c == " " || c == 16'h9 || c == 16'hD || c == 16'hA;
	endfunction

	function automatic logic tstop_u(input logic [15:0] c);
		return space_u(c) || c == "{" || c == "}" || c == "<" || c == ">" ||
			c == "/" || c == "=" || nstart_u(c);
	endfunction

	task automatic push_token(input logic [3:0] k, input logic [15:0] n,
			input logic [23:0] ln, input logic [2:0] e, input logic l);
		token_t t;
		t.kind = k; t.len = n; t.line = ln; t.err = e; t.last = l;
		expected_tokens.push_back(t);
	endtask

	task automatic scan_reset();
		sc_mode = M_IDLE; sc_prog = '0; sc_len = '0;
		sc_start = 24'd1; sc_line = 24'd1; sc_quote = '0; sc_cr = 1'b0;
	endtask

	task automatic scan_open(input mode_t m);
		sc_mode = m; sc_prog = '0; sc_len = 16'd1; sc_start = sc_line;
	endtask

	task automatic scan_grow();
		if (sc_len != 16'hFFFF) sc_len++;
	endtask

	task automatic scan_fail(input logic [3:0] k, input logic [2:0] e);
		push_token(k, sc_len, sc_line, e, 1'b0);
		sc_mode = M_IDLE; sc_prog = '0;
	endtask

	task automatic scan_close(input logic [3:0] k);
		scan_grow();
		push_token(k, sc_len, sc_start, E_NONE, 1'b0);
		sc_mode = M_IDLE; sc_prog = '0;
	endtask

	task automatic scan_idle_unit(input logic [15:0] c);
		case (c)
			"<": scan_open(M_LT);
			"/": scan_open(M_SLASH);
			">": push_token(K_GT, 16'd1, sc_line, E_NONE, 1'b0);
			"{": push_token(K_LBRACE, 16'd1, sc_line, E_NONE, 1'b0);
			"}": push_token(K_RBRACE, 16'd1, sc_line, E_NONE, 1'b0);
			"=": push_token(K_EQ, 16'd1, sc_line, E_NONE, 1'b0);
			"\"", "'": begin
				scan_open(M_STRING);
				sc_quote = c;
			end
			default: begin
				if (space_u(c)) scan_open(M_WS);
				else if (nstart_u(c)) scan_open(M_NAME);
				else scan_open(M_TEXT);
			end
		endcase
	endtask

	task automatic scan_restart(input logic [3:0] k, input logic [15:0] c);
		push_token(k, sc_len, sc_start, E_NONE, 1'b0);
		sc_mode = M_IDLE; sc_prog = '0;
		scan_idle_unit(c);
	endtask

	task automatic scan_end();
		case (sc_mode)
			M_LT, M_WS, M_NAME, M_TEXT: begin
				push_token(sc_mode == M_LT ? K_LT : sc_mode == M_WS ? K_SPACE :
					sc_mode == M_NAME ? K_NAME : K_TEXT, sc_len, sc_start, E_NONE, 1'b0);
				push_token(K_END, 16'd0, sc_line, E_END, 1'b1);
			end
			M_BANG: push_token(K_LT, sc_len, sc_line, E_BANG, 1'b1);
			M_SLASH: push_token(K_EMPTY, sc_len, sc_line, E_SLASH, 1'b1);
			M_CDATA: push_token(K_CDATA, sc_len, sc_start, E_UNTERM, 1'b1);
			M_PI: push_token(K_PI, sc_len, sc_start, E_UNTERM, 1'b1);
			M_COMMENT: begin
				if (sc_prog >= 4'd2) push_token(K_COMMENT, sc_len, sc_line, E_DASH, 1'b1);
				else push_token(K_COMMENT, sc_len, sc_start, E_UNTERM, 1'b1);
			end
			M_STRING: push_token(K_STRING, sc_len, sc_start, E_UNTERM, 1'b1);
			default: push_token(K_END, 16'd0, sc_line, E_END, 1'b1);
		endcase
		scan_reset();
	endtask

	// expected tokens for one accepted beat
	task automatic predict_tokens(input logic is_end, input logic [15:0] c);
		logic [3:0] p;
		p = sc_prog;
		if (is_end) begin
			scan_end();
			return;
		end
		case (sc_mode)
			M_LT: begin
				if (c == "!") begin scan_grow(); sc_mode = M_BANG; sc_prog = '0; end
				else if (c == "?") begin scan_grow(); sc_mode = M_PI; sc_prog = '0; end
				else if (c == "/") scan_close(K_ETAG);
				else scan_restart(K_LT, c);
			end
			M_BANG: begin
				if (p == 4'd0 && c == "[") begin scan_grow(); sc_prog = 4'd1; end
				else if (p == 4'd0 && c == "-") begin scan_grow(); sc_prog = BANG_DASH; end
				else if (p == BANG_DASH && c == "-") begin
					scan_grow(); sc_mode = M_COMMENT; sc_prog = '0;
				end else if (p >= 4'd1 && p <= 4'd6 && c == cdata_at(p)) begin
					scan_grow();
					if (p == 4'd6) begin sc_mode = M_CDATA; sc_prog = '0; end
					else sc_prog = p + 4'd1;
				end else scan_fail(K_LT, E_BANG);
			end
			M_CDATA: begin
				if (p >= 4'd2 && c == ">") scan_close(K_CDATA);
				else begin
					scan_grow();
					sc_prog = (c == "]") ? ((p >= 4'd2) ? 4'd2 : p + 4'd1) : 4'd0;
				end
			end
			M_COMMENT: begin
				if (p >= 4'd2) begin
					if (c == ">") scan_close(K_COMMENT);
					else scan_fail(K_COMMENT, E_DASH);
				end else begin
					scan_grow();
					sc_prog = (c == "-") ? p + 4'd1 : 4'd0;
				end
			end
			M_PI: begin
				if (p == 4'd1 && c == ">") scan_close(K_PI);
				else begin scan_grow(); sc_prog = (c == "?") ? 4'd1 : 4'd0; end
			end
			M_SLASH: begin
				if (c == ">") scan_close(K_EMPTY);
				else scan_fail(K_EMPTY, E_SLASH);
			end
			M_WS: if (space_u(c)) scan_grow(); else scan_restart(K_SPACE, c);
			M_NAME: if (nnext_u(c)) scan_grow(); else scan_restart(K_NAME, c);
			M_TEXT: if (!tstop_u(c)) scan_grow(); else scan_restart(K_TEXT, c);
			M_STRING: if (c == sc_quote) scan_close(K_STRING); else scan_grow();
			default: begin
				sc_mode = M_IDLE; sc_prog = '0;
				scan_idle_unit(c);
			end
		endcase
		// line counting, CR LF as one break
		if (c == 16'hD) begin
			sc_line = sc_line + 24'd1;
			sc_cr = 1'b1;
		end else begin
			if (c == 16'hA && !sc_cr) sc_line = sc_line + 24'd1;
			sc_cr = 1'b0;
		end
	endtask

	// send one beat; prediction happens at acceptance
	task automatic send_beat(input logic is_end, input logic [15:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= is_end;
		s_axis_tdata <= c;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_tokens(is_end, c);
		units_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_beat(1'b0, {8'h00, s[i]});
	endtask

	// receiver stalls and the result check
	always @(posedge clk) begin
		if (arst_n) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		token_t got;
		token_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tdata[3:0];
			got.len = m_axis_tdata[4 +: LB];
			got.line = m_axis_tdata[4+LB +: LN];
			got.err = m_axis_tdata[4+LB+LN +: 3];
			got.last = m_axis_tlast;
			tokens_seen++;
			if (expected_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected token %p", got);
			end else begin
				want = expected_tokens.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("token mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic logic [15:0] pick_unit();
		int r;
		string punct;
		punct = "<>/!?[]-{}=\"' \t\r\n:_.CDAT";
		r = $urandom_range(99);
		if (r < 55) return {8'h00, punct[$urandom_range(punct.len() - 1)]};
		if (r < 75) return 16'(16'h0061 + $urandom_range(25));
		if (r < 82) return 16'(16'h0030 + $urandom_range(9));
		if (r < 86) return (r & 1) ? 16'h00D7 : 16'h00F7;
		if (r < 90) return 16'(16'hFF00 | $urandom_range(255));
		return 16'($urandom_range(16'hFFFF));
	endfunction

	task automatic test_directed();
		send_text("<a b=\"x\">t 1</a><e/>");
		send_text("<![CDATA[x]]]>"); send_text("<!--c-->"); send_text("<?p??>");
		send_beat(1'b0, 16'h000D); send_beat(1'b0, 16'h000A); send_beat(1'b0, 16'h000A);
		send_text("{}'q'"); send_beat(1'b0, 16'h0000); send_beat(1'b0, 16'hFFFF);
		send_beat(1'b0, 16'h00D7); send_beat(1'b0, 16'h00C0); send_beat(1'b1, 16'h0000);
		send_text("<!x"); send_text("/x"); send_text("<!--a--b"); send_beat(1'b1, 16'h0000);
		send_text("<!-"); send_beat(1'b1, 16'h0000);
		send_text("/"); send_beat(1'b1, 16'h0000);
		send_text("<!--a--"); send_beat(1'b1, 16'h0000);
		send_text("<![CD"); send_beat(1'b1, 16'h0000);
		send_text("'ab"); send_beat(1'b1, 16'h0000);
		send_text("<?x"); send_beat(1'b1, 16'h0000);
		send_beat(1'b1, 16'hFFFF);
	endtask

	// markup openers and closers with random content, mixed with end markers
	task automatic test_random(input int n);
		int k;
		int sent;
		sent = 0;
		while (sent < n) begin
			k = $urandom_range(9);
			case (k)
				0: send_text("<![CDATA[");
				1: send_text("<!--");
				2: send_text("<?");
				3: send_text("</");
				4: send_text("]]>");
				5: send_text("-->");
				default: ;
			endcase
			for (int i = $urandom_range(8); i > 0; i--) begin
				send_beat(1'b0, pick_unit());
				sent++;
			end
			if ($urandom_range(19) == 0) begin
				send_beat(1'b1, 16'($urandom_range(16'hFFFF)));
				sent++;
			end
		end
		send_beat(1'b1, 16'h0000);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		scan_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 30; recv_stall_pct = 73;
		test_random(290);
		send_idle_pct = 73; recv_stall_pct = 30;
		test_random(290);
		send_idle_pct = 0; recv_stall_pct = 0;
		test_random(290);
		drain();
		$display("Sent %0d beats and checked %0d tokens over three stall patterns,",
			units_sent, tokens_seen);
		$display("including sections, error cases and end markers in every scan mode.");
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
